// ===== rtl/mtmr_pkg.sv =====
// shared types, constants and the axis mapping function for the mirror tile reader
// no dependencies; imported by every module of the block
`default_nettype none

package mtmr_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int SIZE_W = 5;   // rows_in_use / cols_in_use
  localparam int IDX_W  = 6;   // row_index / col_index
  localparam int VAL_W  = 32;  // element_value / read_value
  localparam int CFG_W  = 1;   // register index
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
  localparam int EXT_W  = SIZE_W + 2;  // holds 3 * size

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [CFG_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_W-1:0] REG_COLS = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic [VAL_W-1:0]   element_value;
  } item_t;

  typedef struct packed {
    logic              wr_ok;   // write lands inside the source matrix
    logic              rd_ok;   // read lands inside the tiled matrix
    logic [ADDR_W-1:0] addr;
  } mem_ctrl_t;

  typedef struct packed {
    logic              ok;
    logic [EXT_W-1:0]  src;
  } axis_map_t;

  // output coordinate to source coordinate along one axis of the 3x3 tiling
  function automatic axis_map_t map_axis(input logic [IDX_W-1:0] pos,
                                         input logic [SIZE_W-1:0] size);
    logic [EXT_W-1:0] p;
    logic [EXT_W-1:0] s1;
    logic [EXT_W-1:0] s2;
    logic [EXT_W-1:0] s3;
    axis_map_t        res;
    p  = EXT_W'(pos);
    s1 = EXT_W'(size);
    s2 = s1 << 1;
    s3 = s1 + s2;
    res.ok = (p < s3);
    if (p < s1) begin
      res.src = s1 - 1'b1 - p;
    end else if (p < s2) begin
      res.src = p - s1;
    end else begin
      res.src = s3 - 1'b1 - p;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mtmr_addr.sv =====
// address and range decode for one item: write bounds check or mirrored read mapping
// depends on mtmr_pkg
`default_nettype none

module mtmr_addr (
  input  wire mtmr_pkg::item_t            item,
  input  wire [mtmr_pkg::SIZE_W-1:0]      rows_in_use,
  input  wire [mtmr_pkg::SIZE_W-1:0]      cols_in_use,
  output mtmr_pkg::mem_ctrl_t             ctrl
);
  import mtmr_pkg::*;

  axis_map_t         row_map;
  axis_map_t         col_map;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_rows;
  logic              in_cols;

  always_comb begin
    row_map = map_axis(item.row_index, rows_in_use);
    col_map = map_axis(item.col_index, cols_in_use);

    in_rows = (item.row_index < IDX_W'(rows_in_use));
    in_cols = (item.col_index < IDX_W'(cols_in_use));

    wr_addr = ADDR_W'(item.row_index[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
            + ADDR_W'(item.col_index[COL_W-1:0]);
    rd_addr = ADDR_W'(row_map.src[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
            + ADDR_W'(col_map.src[COL_W-1:0]);

    ctrl.wr_ok = (item.kind == KIND_WRITE) && in_rows && in_cols;
    ctrl.rd_ok = (item.kind == KIND_READ) && row_map.ok && col_map.ok;
    ctrl.addr  = (item.kind == KIND_WRITE) ? wr_addr : rd_addr;
  end

endmodule

`default_nettype wire

// ===== rtl/mtmr_store.sv =====
// single-port element store with registered read data
// depends on mtmr_pkg
`default_nettype none

module mtmr_store (
  input  wire                             clk,
  input  wire                             en,
  input  wire                             we,
  input  wire [mtmr_pkg::ADDR_W-1:0]      addr,
  input  wire [mtmr_pkg::DATA_WIDTH-1:0]  wdata,
  output logic [mtmr_pkg::DATA_WIDTH-1:0] rdata
);
  import mtmr_pkg::*;

  logic [DATA_WIDTH-1:0] mem [MAX_ROWS*MAX_COLS];

  // read data holds when not enabled so a stalled result keeps its value
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mirror_tile_matrix_reader_unit.sv =====
// mirror tile matrix reader: beats held in s1, read results in the output register
// one item per cycle while no read waits on a stalled output; writes give no result
// at most one store access per item through a single-port memory
// rst (synchronous) clears the valid flags and sets both sizes to 0
// store contents are not cleared; the user must write entries before reading them
// the block has no check for this; depends on mtmr_pkg, mtmr_addr, mtmr_store
`default_nettype none

module mirror_tile_matrix_reader_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write_enable,
  input  wire [mtmr_pkg::CFG_W-1:0]        cfg_index,
  input  wire [mtmr_pkg::SIZE_W-1:0]       cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              kind,
  input  wire [mtmr_pkg::IDX_W-1:0]        row_index,
  input  wire [mtmr_pkg::IDX_W-1:0]        col_index,
  input  wire signed [mtmr_pkg::VAL_W-1:0] element_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [mtmr_pkg::VAL_W-1:0] read_value,
  output logic                             read_status
);
  import mtmr_pkg::*;

  logic [SIZE_W-1:0]     rows_in_use;
  logic [SIZE_W-1:0]     cols_in_use;
  logic [SIZE_W-1:0]     cfg_rows_next;
  logic [SIZE_W-1:0]     cfg_cols_next;

  logic                  s1_valid;
  item_t                 s1_item;
  mem_ctrl_t             ctrl;
  logic                  out_free;
  logic                  s1_is_read;
  logic                  s1_advance;
  logic                  in_accept;
  logic                  mem_en;
  logic                  mem_we;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // sizes saturate at the store dimensions
  assign cfg_rows_next = (cfg_data > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : cfg_data;
  assign cfg_cols_next = (cfg_data > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= '0;
      cols_in_use <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_rows_next;
        REG_COLS: cols_in_use <= cfg_cols_next;
        default:  ;
      endcase
    end
  end

  // writes never need the output register, reads need it free
  assign out_free   = !out_valid || !out_stall;
  assign s1_is_read = (s1_item.kind == KIND_READ);
  assign s1_advance = s1_valid && (!s1_is_read || out_free);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.kind          <= kind;
      s1_item.row_index     <= row_index;
      s1_item.col_index     <= col_index;
      s1_item.element_value <= element_value;
    end
  end

  mtmr_addr u_addr (
    .item        (s1_item),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .ctrl        (ctrl)
  );

  assign mem_we = s1_valid && !s1_is_read && ctrl.wr_ok;
  assign mem_en = mem_we || (s1_valid && s1_is_read && out_free);

  mtmr_store u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (ctrl.addr),
    .wdata (DATA_WIDTH'(s1_item.element_value)),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && s1_is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && s1_is_read) begin
      read_status <= ctrl.rd_ok ? STATUS_OK : STATUS_RANGE;
    end
  end

  assign read_value = (read_status == STATUS_RANGE) ? '0 : VAL_W'(mem_rdata);

endmodule

`default_nettype wire
